@@ rtl/ltr_eval_pkg.sv @@
// shared types, character codes and decode helpers for the expression evaluator
package ltr_eval_pkg;

    // ascii codes of interest
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef logic [1:0] op_t;

    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic digit_en;
        logic latch_op;
        logic fold_simple;
        logic div_zero;
        logic iter_start;
        logic iter_step;
        logic set_op;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic first;
        op_t  op;
        logic operand_zero;
        logic iter_last;
    } dp_status_t;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_operator(input logic [7:0] ch);
        return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
    endfunction

    function automatic op_t op_of_char(input logic [7:0] ch);
        op_t op;
        case (ch)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            default:  op = OP_DIV;
        endcase
        return op;
    endfunction

endpackage

@@ rtl/ltr_eval_dp.sv @@
// datapath: operand and sum registers, shared shift-add / restoring divide unit, result register
module ltr_eval_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [7:0]                  character,
    input  ltr_eval_pkg::dp_cmd_t       cmd,
    output ltr_eval_pkg::dp_status_t    status,
    output logic [VALUE_WIDTH-1:0]      value,
    output logic                        div_err
);
    import ltr_eval_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [W-1:0]     sum_reg, sum_next;
    logic [W-1:0]     operand_reg, operand_next;
    op_t              op_reg, op_next;
    op_t              new_op_reg;
    logic             first_reg, first_next;
    logic             err_reg, err_next;

    logic [W-1:0]     acc_reg, a_reg, b_reg;
    logic [W-1:0]     acc_step, a_step, b_step;
    logic             div_mode_reg, neg_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [W-1:0]     out_value_reg;
    logic             out_err_reg;

    logic [W-1:0]     digit_val;
    logic [W-1:0]     sum_abs, operand_abs;
    logic [W-1:0]     rem_shift;
    logic             rem_ge;
    logic [W-1:0]     iter_result;

    assign digit_val   = W'(character - CH_ZERO);
    assign sum_abs     = sum_reg[W-1] ? ({W{1'b0}} - sum_reg) : sum_reg;
    assign operand_abs = operand_reg[W-1] ? ({W{1'b0}} - operand_reg) : operand_reg;

    // one bit of multiply or divide per cycle
    always_comb
    begin
        rem_shift = {acc_reg[W-2:0], a_reg[W-1]};
        rem_ge    = rem_shift >= b_reg;
        if (div_mode_reg)
        begin
            acc_step = rem_ge ? (rem_shift - b_reg) : rem_shift;
            a_step   = {a_reg[W-2:0], rem_ge};
            b_step   = b_reg;
        end
        else
        begin
            acc_step = acc_reg + (a_reg[0] ? b_reg : {W{1'b0}});
            a_step   = {1'b0, a_reg[W-1:1]};
            b_step   = {b_reg[W-2:0], 1'b0};
        end
        if (div_mode_reg)
            iter_result = neg_reg ? ({W{1'b0}} - a_step) : a_step;
        else
            iter_result = acc_step;
    end

    always_comb
    begin
        sum_next     = sum_reg;
        operand_next = operand_reg;
        op_next      = op_reg;
        first_next   = first_reg;
        err_next     = err_reg;

        if (cmd.digit_en)
            operand_next = (operand_reg << 3) + (operand_reg << 1) + digit_val;

        if (cmd.fold_simple)
        begin
            operand_next = '0;
            if (first_reg)
            begin
                sum_next   = operand_reg;
                first_next = 1'b0;
            end
            else
            begin
                case (op_reg)
                    OP_ADD:  sum_next = sum_reg + operand_reg;
                    OP_SUB:  sum_next = sum_reg - operand_reg;
                    default: sum_next = sum_reg;
                endcase
            end
        end

        if (cmd.div_zero)
        begin
            err_next     = 1'b1;
            operand_next = '0;
        end

        if (cmd.iter_start)
            operand_next = '0;

        if (cmd.iter_step && (cnt_reg == '0))
            sum_next = iter_result;

        if (cmd.set_op)
            op_next = new_op_reg;

        if (cmd.emit)
        begin
            sum_next     = '0;
            operand_next = '0;
            op_next      = OP_ADD;
            first_next   = 1'b1;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            operand_reg <= '0;
            op_reg      <= OP_ADD;
            first_reg   <= 1'b1;
            err_reg     <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            operand_reg <= operand_next;
            op_reg      <= op_next;
            first_reg   <= first_next;
            err_reg     <= err_next;
        end
    end

    // iteration unit and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_op)
            new_op_reg <= op_of_char(character);

        if (cmd.iter_start)
        begin
            div_mode_reg <= (op_reg == OP_DIV);
            neg_reg      <= sum_reg[W-1] ^ operand_reg[W-1];
            acc_reg      <= '0;
            cnt_reg      <= CNT_W'(W - 1);
            if (op_reg == OP_DIV)
            begin
                a_reg <= sum_abs;
                b_reg <= operand_abs;
            end
            else
            begin
                a_reg <= operand_reg;
                b_reg <= sum_reg;
            end
        end
        else if (cmd.iter_step)
        begin
            acc_reg <= acc_step;
            a_reg   <= a_step;
            b_reg   <= b_step;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end

        if (cmd.emit)
        begin
            out_value_reg <= sum_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign status.first        = first_reg;
    assign status.op           = op_reg;
    assign status.operand_zero = (operand_reg == '0);
    assign status.iter_last    = (cnt_reg == '0);

    assign value   = out_value_reg;
    assign div_err = out_err_reg;

endmodule

@@ rtl/ltr_eval_ctrl.sv @@
// controller: sequences byte intake, operand folds, iterations and result hand-off
module ltr_eval_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  character,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  ltr_eval_pkg::dp_status_t    status,
    output ltr_eval_pkg::dp_cmd_t       cmd
);
    import ltr_eval_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FOLD   = 2'd1;
    localparam logic [1:0] ST_ITER   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic       setop_reg, setop_next;
    logic       out_valid_reg, out_valid_next;
    logic       fold_done;

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        setop_next     = setop_reg;
        out_valid_next = out_valid_reg && !m_tready;
        fold_done      = 1'b0;
        cmd            = '0;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.digit_en = is_digit(character);
                    if (is_operator(character))
                    begin
                        cmd.latch_op = 1'b1;
                        setop_next   = 1'b1;
                        last_next    = s_tlast;
                        state_next   = ST_FOLD;
                    end
                    else if (s_tlast)
                    begin
                        setop_next = 1'b0;
                        last_next  = 1'b1;
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_FOLD:
            begin
                if (status.first || (status.op == OP_ADD) || (status.op == OP_SUB))
                begin
                    cmd.fold_simple = 1'b1;
                    fold_done       = 1'b1;
                end
                else if ((status.op == OP_DIV) && status.operand_zero)
                begin
                    cmd.div_zero = 1'b1;
                    fold_done    = 1'b1;
                end
                else
                begin
                    cmd.iter_start = 1'b1;
                    state_next     = ST_ITER;
                end
            end
            ST_ITER:
            begin
                cmd.iter_step = 1'b1;
                fold_done     = status.iter_last;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // after a fold: take a pending new operator, then fold again or return to intake; with none pending, finish
        if (fold_done)
        begin
            if (setop_reg)
            begin
                cmd.set_op = 1'b1;
                setop_next = 1'b0;
                state_next = last_reg ? ST_FOLD : ST_IDLE;
            end
            else
            begin
                state_next = ST_FINISH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            setop_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            setop_reg     <= setop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/left_to_right_expression_evaluator.sv @@
// top level of the left-to-right expression evaluator
//
// Takes an expression one byte per request. A digit byte or an ignored byte is
// taken while intake stays open, and the next request is accepted right away. An
// operator byte, or any byte marked last, folds the pending operand into the
// running sum: directly for add, subtract or the first operand, while multiply
// and divide share one iterative unit that, after a start step, does a shift-add
// or restoring-divide step per cycle across all VALUE_WIDTH bits. A byte marked
// last then moves the result into the output register, and an operator marked
// last folds twice (its own operand, then the empty final operand). A finished
// result waits in the output register while the next expression is already
// being taken in; only a second result stalls behind an untaken one. Division
// by zero leaves the sum as it is and raises the status flag for the rest of
// the expression; values wrap at VALUE_WIDTH bits.
module left_to_right_expression_evaluator #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input request
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] character
    input  logic                                 s_tlast,   // last_char
    // result request
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,   // [VALUE_WIDTH-1:0] value, zero pad
    output logic                                 m_tuser    // status: 1 division by zero
);
    import ltr_eval_pkg::*;

    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [VALUE_WIDTH-1:0] value;
    logic                   div_err;

    // sequencing of each request
    ltr_eval_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .character (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // operand, sum, iterative mul/div and result register
    ltr_eval_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .character (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .div_err   (div_err)
    );

    // value is zero-extended to whole bytes
    assign m_tdata = TDATA_W'(value);
    assign m_tuser = div_err;

endmodule

@@ rtl/ltr_eval_checker.sv @@
// port-level checks for the expression evaluator and their binding
module ltr_eval_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [7:0]                       s_tdata,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic                             m_tuser
);
    import ltr_eval_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a byte not marked last never produces a new result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result without a last byte");

    // a last byte stops intake while the expression is closed out
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after a last byte");

    // digits not marked last are taken back to back
    a_digit_rate: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE)
        |=> s_tready)
        else $error("digit stalled the input");

    // a new result appears only while intake is held off
    a_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised during intake");

endmodule

bind left_to_right_expression_evaluator ltr_eval_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ltr_eval_checker (.*);

@@ dv/tb_left_to_right_expression_evaluator.sv @@
// self-checking testbench for the left-to-right expression evaluator
`timescale 1ns / 1ps

module tb_left_to_right_expression_evaluator;

    import ltr_eval_pkg::*;

    localparam int VALUE_W     = 32;
    localparam int DATA_W      = ((VALUE_W + 7) / 8) * 8;
    // longest request is two iterative folds plus the output move; add the longest
    // sender gap and result stall and keep a wide margin
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               status;
    } eval_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input request side
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;   // [7:0] character
    logic              s_tlast  = 1'b0;    // last_char

    // result request side
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;            // [VALUE_W-1:0] value, zero pad
    logic              m_tuser;            // status: 1 division by zero

    // evaluator state as the testbench sees it
    logic [VALUE_W-1:0] acc_value;
    logic [VALUE_W-1:0] operand_acc;
    op_t                next_op;
    logic               awaiting_first;
    logic               saw_div_zero;

    // results still owed by the block, oldest first
    eval_result_t expected_results[$];

    int   error_count  = 0;
    int   items_sent   = 0;
    int   quiet_cycles = 0;
    int   ready_hold   = 0;
    // when set, both sides run at full rate with no gaps or stalls
    bit   no_gaps      = 1'b0;
    eval_result_t oldest;

    left_to_right_expression_evaluator #(
        .VALUE_WIDTH(VALUE_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // expected-value side
    // ------------------------------------------------------------------

    // signed quotient truncated toward zero, done on magnitudes so that
    // the most negative value over -1 wraps back to itself
    function automatic logic [VALUE_W-1:0] div_toward_zero(input logic [VALUE_W-1:0] a,
                                                           input logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] mag_a;
        logic [VALUE_W-1:0] mag_b;
        logic [VALUE_W-1:0] quo;
        mag_a = a[VALUE_W-1] ? -a : a;
        mag_b = b[VALUE_W-1] ? -b : b;
        quo   = mag_a / mag_b;
        return (a[VALUE_W-1] ^ b[VALUE_W-1]) ? -quo : quo;
    endfunction

    function automatic void clear_evaluator();
        acc_value      = '0;
        operand_acc    = '0;
        next_op        = OP_ADD;
        awaiting_first = 1'b1;
        saw_div_zero   = 1'b0;
    endfunction

    // fold the operand built so far into the accumulated value
    function automatic void apply_operand();
        if (awaiting_first)
        begin
            // first operand just loads the value, no operation
            acc_value      = operand_acc;
            awaiting_first = 1'b0;
        end
        else
        begin
            case (next_op)
                OP_ADD: acc_value = acc_value + operand_acc;
                OP_SUB: acc_value = acc_value - operand_acc;
                OP_MUL: acc_value = acc_value * operand_acc;
                default:
                begin
                    // divide by zero keeps the value and flags the expression
                    if (operand_acc == '0)
                        saw_div_zero = 1'b1;
                    else
                        acc_value = div_toward_zero(acc_value, operand_acc);
                end
            endcase
        end
        operand_acc = '0;
    endfunction

    // advance the expected state by one accepted character; returns 1 when
    // the character is not simply ignored
    function automatic bit eval_char(input logic [7:0] ch, input logic last);
        bit useful;
        useful = last;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            operand_acc = operand_acc * VALUE_W'(10) + VALUE_W'(ch - CH_ZERO);
            useful = 1'b1;
        end
        else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH)
        begin
            apply_operand();
            case (ch)
                CH_PLUS:  next_op = OP_ADD;
                CH_MINUS: next_op = OP_SUB;
                CH_STAR:  next_op = OP_MUL;
                default:  next_op = OP_DIV;
            endcase
            useful = 1'b1;
        end
        if (last)
        begin
            // final operand, which may be empty after a trailing operator
            apply_operand();
            expected_results.push_back('{value: acc_value, status: saw_div_zero});
            clear_evaluator();
        end
        return useful;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // mostly back to back, often short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] random_digit();
        logic [7:0] ch;
        ch = CH_ZERO + 8'($urandom_range(0, 9));
        return ch;
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] random_byte();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        return ch;
    endfunction

    // empty operands now and then, mostly short, a few long enough to wrap
    function automatic int random_digit_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 9);
        return $urandom_range(10, 13);
    endfunction

    // ------------------------------------------------------------------
    // checking and reporting
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // every accepted result is compared with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with none pending, value", 64'(m_tdata), '0);
            else
            begin
                oldest = expected_results.pop_front();
                if (m_tdata[VALUE_W-1:0] !== oldest.value)
                    report_mismatch("value", 64'(m_tdata[VALUE_W-1:0]), 64'(oldest.value));
                if (m_tuser !== oldest.status)
                    report_mismatch("status", 64'(m_tuser), 64'(oldest.status));
            end
        end
    end

    // result side back-pressure: runs of ready broken by random stalls
    always @(posedge clk)
    begin
        if (no_gaps)
        begin
            ready_hold = 0;
            m_tready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            ready_hold = pick_gap();
            m_tready <= (ready_hold == 0);
            if (ready_hold > 0)
                ready_hold--;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog: too long without any request moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offer one character, wait for the handshake, then update the expectation
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (eval_char(ch, last))
            items_sent++;
    endtask

    task automatic send_expr(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], i == text.len() - 1);
    endtask

    // well-formed expression with random content, sometimes with a stray
    // byte inside or a trailing operator or junk byte carrying the last mark
    task automatic send_random_expr();
        logic [7:0] chars[$];
        int         n_terms;
        int         n_digits;
        int         ending;
        n_terms = $urandom_range(1, 5);
        for (int t = 0; t < n_terms; t++)
        begin
            if (t > 0)
                chars.push_back(random_operator());
            n_digits = random_digit_count();
            for (int d = 0; d < n_digits; d++)
            begin
                if ($urandom_range(0, 24) == 0)
                    chars.push_back(random_byte());
                chars.push_back(random_digit());
            end
        end
        ending = $urandom_range(0, 9);
        if (ending == 8)
            chars.push_back(random_operator());
        else if (ending == 9)
            chars.push_back(random_byte());
        else if (chars.size() == 0)
            chars.push_back(random_digit());
        foreach (chars[i])
            send_char(chars[i], i == chars.size() - 1);
    endtask

    // stop offering requests until the block has returned every result
    task automatic hold_off_until_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // extremes and the corner cases of the arithmetic
    task automatic test_directed();
        // most negative first operand, 11-digit divisor that wraps to -1,
        // then a divide by zero on the byte marked last
        send_expr("2147483648/12884901887/0");
        // subtract, empty operand after '+', operator carrying the last mark
        send_expr("5-+*");
        // expression with no digits at all, all-ones junk byte
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_random_expressions(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_random_expr();
    endtask

    // arbitrary bytes, last mark at a random place
    task automatic test_noise(input int expressions);
        int len;
        for (int e = 0; e < expressions; e++)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_char(random_byte(), i == len - 1);
        end
    endtask

    // full rate on both sides
    task automatic test_back_to_back(input int count);
        no_gaps = 1'b1;
        test_random_expressions(count);
        no_gaps = 1'b0;
    endtask

    // results come back with the sender quiet, then traffic resumes
    task automatic test_drain_pause();
        repeat (4) send_random_expr();
        hold_off_until_drained();
        repeat (4) send_random_expr();
        hold_off_until_drained();
        test_random_expressions(40);
    endtask

    initial
    begin
        clear_evaluator();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_expressions(220);
        test_noise(40);
        test_back_to_back(120);
        test_drain_pause();
        test_random_expressions(180);

        // drop valid, wait for the last results and a little longer
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ltr_eval_pkg.sv
rtl/ltr_eval_dp.sv
rtl/ltr_eval_ctrl.sv
rtl/left_to_right_expression_evaluator.sv
rtl/ltr_eval_checker.sv
dv/tb_left_to_right_expression_evaluator.sv
